// ===== src/mfrk_pkg.sv =====
`timescale 1ns / 1ps

package mfrk_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 12;

  localparam int QUARTER_TURN = 9000;
  localparam int FULL_TURN    = 36000;

  // floor(x / 100) as (x * RECIP_IDX) >> RECIP_IDX_SH, exact for x <= 9000
  localparam int RECIP_IDX    = 5243;
  localparam int RECIP_IDX_SH = 19;
  // floor(y / 100) as (y * RECIP_FRAC) >> RECIP_FRAC_SH, exact for y < 91180
  localparam int RECIP_FRAC    = 83887;
  localparam int RECIP_FRAC_SH = 23;

  localparam int RAD_PER_DEG_Q16 = 1144;

  typedef struct packed {
    logic [10:0] wheelbase;
    logic [10:0] wheeltrack;
    logic [10:0] offset_x;
    logic [10:0] offset_y;
    logic [15:0] rpm_scale;
    logic [14:0] max_vx;
    logic [14:0] max_vy;
    logic [11:0] max_turn;
  } cfg_t;

  // sin(k deg) * 32767, k = 0..90
  localparam logic [14:0] SINE_TAB [91] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
    15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
    15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
    15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14364, 15'd14876,
    15'd15383, 15'd15886, 15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
    15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621, 15'd21062, 15'd21497,
    15'd21925, 15'd22347, 15'd22762, 15'd23170, 15'd23571, 15'd23964, 15'd24351,
    15'd24730, 15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509, 15'd26841,
    15'd27165, 15'd27481, 15'd27788, 15'd28087, 15'd28377, 15'd28659, 15'd28932,
    15'd29196, 15'd29451, 15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
    15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498, 15'd31650, 15'd31794,
    15'd31927, 15'd32051, 15'd32165, 15'd32269, 15'd32364, 15'd32448, 15'd32523,
    15'd32587, 15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762, 15'd32767
  };

  function automatic logic [14:0] sine_lut(input logic [6:0] idx);
    logic [14:0] val;
    if (idx > 7'd90) begin
      val = 15'd32767;
    end else begin
      val = SINE_TAB[idx];
    end
    return val;
  endfunction

endpackage

// ===== src/mfrk_cfg.sv =====
`timescale 1ns / 1ps

module mfrk_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  output mfrk_pkg::cfg_t       cfg_o
);

  localparam logic [2:0] REG_WHEELBASE  = 3'd0;
  localparam logic [2:0] REG_WHEELTRACK = 3'd1;
  localparam logic [2:0] REG_OFFSET_X   = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd3;
  localparam logic [2:0] REG_RPM_SCALE  = 3'd4;
  localparam logic [2:0] REG_MAX_VX     = 3'd5;
  localparam logic [2:0] REG_MAX_VY     = 3'd6;
  localparam logic [2:0] REG_MAX_TURN   = 3'd7;

  mfrk_pkg::cfg_t cfg_r;
  mfrk_pkg::cfg_t cfg_nxt;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_o      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WHEELBASE:  cfg_nxt.wheelbase  = cfg_pwdata[10:0];
        REG_WHEELTRACK: cfg_nxt.wheeltrack = cfg_pwdata[10:0];
        REG_OFFSET_X:   cfg_nxt.offset_x   = cfg_pwdata[10:0];
        REG_OFFSET_Y:   cfg_nxt.offset_y   = cfg_pwdata[10:0];
        REG_RPM_SCALE:  cfg_nxt.rpm_scale  = cfg_pwdata[15:0];
        REG_MAX_VX:     cfg_nxt.max_vx     = cfg_pwdata[14:0];
        REG_MAX_VY:     cfg_nxt.max_vy     = cfg_pwdata[14:0];
        REG_MAX_TURN:   cfg_nxt.max_turn   = cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WHEELBASE:  cfg_prdata = {21'd0, cfg_r.wheelbase};
      REG_WHEELTRACK: cfg_prdata = {21'd0, cfg_r.wheeltrack};
      REG_OFFSET_X:   cfg_prdata = {21'd0, cfg_r.offset_x};
      REG_OFFSET_Y:   cfg_prdata = {21'd0, cfg_r.offset_y};
      REG_RPM_SCALE:  cfg_prdata = {16'd0, cfg_r.rpm_scale};
      REG_MAX_VX:     cfg_prdata = {17'd0, cfg_r.max_vx};
      REG_MAX_VY:     cfg_prdata = {17'd0, cfg_r.max_vy};
      REG_MAX_TURN:   cfg_prdata = {20'd0, cfg_r.max_turn};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheelbase  <= 11'd400;
      cfg_r.wheeltrack <= 11'd400;
      cfg_r.offset_x   <= 11'd0;
      cfg_r.offset_y   <= 11'd0;
      cfg_r.rpm_scale  <= 16'd433;
      cfg_r.max_vx     <= 15'd4000;
      cfg_r.max_vy     <= 15'd4000;
      cfg_r.max_turn   <= 12'd360;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/mfrk_sincos.sv =====
`timescale 1ns / 1ps

module mfrk_sincos (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [15:0] yaw,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam logic [15:0] Q1 = 16'(mfrk_pkg::QUARTER_TURN);
  localparam logic [15:0] Q2 = 16'(2 * mfrk_pkg::QUARTER_TURN);
  localparam logic [15:0] Q3 = 16'(3 * mfrk_pkg::QUARTER_TURN);
  localparam logic [16:0] FULL = 17'(mfrk_pkg::FULL_TURN);
  localparam logic [13:0] QSPAN = 14'(mfrk_pkg::QUARTER_TURN);
  localparam int ISH = mfrk_pkg::RECIP_IDX_SH;
  localparam int FSH = mfrk_pkg::RECIP_FRAC_SH;
  localparam logic [26:0] KIDX  = 27'(mfrk_pkg::RECIP_IDX);
  localparam logic [33:0] KFRAC = 34'(mfrk_pkg::RECIP_FRAC);

  // lane 0 is sine, lane 1 is cosine
  logic [16:0] t_ext;
  logic [15:0] t;
  logic [15:0] r_wide;
  logic [13:0] r;
  logic [1:0]  quad_s;
  logic [1:0]  quad_c;

  logic [13:0] x_nxt    [2];
  logic        neg1_nxt [2];
  logic [13:0] x_r      [2];
  logic        neg1_r   [2];

  logic [26:0] idx_prod [2];
  logic [13:0] rem_w    [2];
  logic [6:0]  idx_nxt  [2];
  logic [6:0]  frac_nxt [2];
  logic [6:0]  idx_r    [2];
  logic [6:0]  frac_r   [2];
  logic        neg2_r   [2];

  logic [14:0] lo_nxt   [2];
  logic [14:0] hi_w     [2];
  logic [14:0] diff_w   [2];
  logic [16:0] step_nxt [2];
  logic [14:0] lo_r     [2];
  logic [16:0] step_r   [2];
  logic        neg3_r   [2];

  logic [33:0]        quo_w [2];
  logic [14:0]        mag_w [2];
  logic signed [15:0] val_nxt [2];
  logic signed [15:0] val_r   [2];

  always_comb begin
    t_ext = {yaw[15], yaw} + (yaw[15] ? FULL : 17'd0);
    t     = t_ext[15:0];
    if (t >= Q3) begin
      quad_s = 2'd3;
      r_wide = t - Q3;
    end else if (t >= Q2) begin
      quad_s = 2'd2;
      r_wide = t - Q2;
    end else if (t >= Q1) begin
      quad_s = 2'd1;
      r_wide = t - Q1;
    end else begin
      quad_s = 2'd0;
      r_wide = t;
    end
    r      = r_wide[13:0];
    quad_c = quad_s + 2'd1;
    x_nxt[0]    = quad_s[0] ? (QSPAN - r) : r;
    neg1_nxt[0] = quad_s[1];
    x_nxt[1]    = quad_c[0] ? (QSPAN - r) : r;
    neg1_nxt[1] = quad_c[1];
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      idx_prod[l] = 27'(x_r[l]) * KIDX;
      idx_nxt[l]  = idx_prod[l][ISH+6:ISH];
      rem_w[l]    = x_r[l] - 14'(idx_nxt[l]) * 14'd100;
      frac_nxt[l] = rem_w[l][6:0];

      lo_nxt[l]   = mfrk_pkg::sine_lut(idx_r[l]);
      hi_w[l]     = mfrk_pkg::sine_lut(idx_r[l] + 7'd1);
      diff_w[l]   = hi_w[l] - lo_nxt[l];
      step_nxt[l] = 17'(diff_w[l][9:0]) * 17'(frac_r[l]) + 17'd50;

      quo_w[l]    = 34'(step_r[l]) * KFRAC;
      mag_w[l]    = lo_r[l] + 15'(quo_w[l][FSH+10:FSH]);
      val_nxt[l]  = neg3_r[l] ? -$signed({1'b0, mag_w[l]}) : $signed({1'b0, mag_w[l]});
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en[0]) begin
        x_r[l]    <= x_nxt[l];
        neg1_r[l] <= neg1_nxt[l];
      end
      if (en[1]) begin
        idx_r[l]  <= idx_nxt[l];
        frac_r[l] <= frac_nxt[l];
        neg2_r[l] <= neg1_r[l];
      end
      if (en[2]) begin
        lo_r[l]   <= lo_nxt[l];
        step_r[l] <= step_nxt[l];
        neg3_r[l] <= neg2_r[l];
      end
      if (en[3]) begin
        val_r[l] <= val_nxt[l];
      end
    end
  end

  assign sin_o = val_r[0];
  assign cos_o = val_r[1];

endmodule

// ===== src/mfrk_wheel.sv =====
`timescale 1ns / 1ps

module mfrk_wheel #(
  parameter int GAIN_FRAC_BITS = mfrk_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic [5:0]                en,
  input  logic signed [17:0]        lin,
  input  logic signed [12:0]        turn,
  input  logic signed [13:0]        arm2,
  input  logic [15:0]               rpm_scale,
  input  logic [GAIN_FRAC_BITS+2:0] gain,
  output logic signed [16:0]        rpm_o
);

  localparam int GW  = GAIN_FRAC_BITS + 3;
  localparam int MW  = 31 + GW + 1;
  localparam int RSH = 16 + GAIN_FRAC_BITS;
  localparam int RW  = MW - RSH;
  localparam logic [MW-1:0]         RND   = MW'(1) << (RSH - 1);
  localparam logic signed [11:0]    RAD_K = 12'(mfrk_pkg::RAD_PER_DEG_Q16);
  localparam logic signed [38:0]    QMAX  = 39'sd1073741823;
  localparam logic signed [38:0]    QMIN  = -39'sd1073741824;
  localparam logic signed [RW-1:0]  SMAX  = RW'(65535);
  localparam logic signed [RW-1:0]  SMIN  = RW'(-65536);
  localparam logic signed [16:0]    OUT_MAX = 17'h0FFFF;
  localparam logic signed [16:0]    OUT_MIN = 17'h10000;

  logic signed [26:0] p8_nxt;
  logic signed [26:0] p8_r;
  logic signed [17:0] lin8_r;
  logic [GW-1:0]      gain8_r;

  logic signed [37:0] lin_sh;
  logic signed [37:0] pk;
  logic signed [37:0] s9_nxt;
  logic signed [37:0] s9_r;
  logic [GW-1:0]      gain9_r;

  logic signed [34:0] ph10_nxt;
  logic [35:0]        pl10_nxt;
  logic signed [34:0] ph10_r;
  logic [35:0]        pl10_r;
  logic [GW-1:0]      gain10_r;

  logic [55:0]        sum56;
  logic signed [38:0] qw;
  logic signed [30:0] q11_nxt;
  logic signed [30:0] q11_r;
  logic [GW-1:0]      gain11_r;

  logic signed [MW-1:0] m12_nxt;
  logic signed [MW-1:0] m12_r;

  logic [MW-1:0]        w13;
  logic signed [RW-1:0] r13;
  logic signed [16:0]   rpm13_nxt;
  logic signed [16:0]   rpm13_r;

  always_comb begin
    p8_nxt   = turn * arm2;

    lin_sh   = {{3{lin8_r[17]}}, lin8_r, 17'd0};
    pk       = p8_r * RAD_K;
    s9_nxt   = lin_sh - pk;

    ph10_nxt = $signed(s9_r[37:20]) * $signed({1'b0, rpm_scale});
    pl10_nxt = s9_r[19:0] * rpm_scale;

    sum56 = {ph10_r[34], ph10_r, 20'd0} + {20'd0, pl10_r} + (56'd1 << 16);
    qw    = $signed(sum56[55:17]);
    if (qw > QMAX) begin
      q11_nxt = QMAX[30:0];
    end else if (qw < QMIN) begin
      q11_nxt = QMIN[30:0];
    end else begin
      q11_nxt = qw[30:0];
    end

    m12_nxt = q11_r * $signed({1'b0, gain11_r});

    w13 = m12_r + RND;
    r13 = $signed(w13[MW-1:RSH]);
    if (r13 > SMAX) begin
      rpm13_nxt = OUT_MAX;
    end else if (r13 < SMIN) begin
      rpm13_nxt = OUT_MIN;
    end else begin
      rpm13_nxt = r13[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p8_r    <= p8_nxt;
      lin8_r  <= lin;
      gain8_r <= gain;
    end
    if (en[1]) begin
      s9_r    <= s9_nxt;
      gain9_r <= gain8_r;
    end
    if (en[2]) begin
      ph10_r   <= ph10_nxt;
      pl10_r   <= pl10_nxt;
      gain10_r <= gain9_r;
    end
    if (en[3]) begin
      q11_r    <= q11_nxt;
      gain11_r <= gain10_r;
    end
    if (en[4]) begin
      m12_r <= m12_nxt;
    end
    if (en[5]) begin
      rpm13_r <= rpm13_nxt;
    end
  end

  assign rpm_o = rpm13_r;

endmodule

// ===== src/mecanum_field_relative_kinematics.sv =====
// Field-relative mecanum wheel speeds. Each request carries a gimbal yaw
// (0.01 deg), a velocity command in the gimbal frame and two gain flags; the
// block rotates the velocity into the chassis frame, clamps it to the
// configured limits and returns the four wheel rpm targets, saturated to 17
// bits. The path is a 14-stage pipeline (angle reduction, table interpolation,
// rotation multiplies, clamping, lever-arm and rpm multiplies, gain multiply,
// saturation) with one item accepted per clock unless every stage is full and
// the output is stalled. A stage holds only while it and every later stage are
// full and out_tready is low, so the input keeps taking requests while a result
// waits until every stage is occupied. Registers sit at byte address 4*i on
// the APB port in the order wheelbase, track, offset x, offset y, rpm scale,
// max vx, max vy, max turn rate; write them only while no request is in flight.
`timescale 1ns / 1ps

module mecanum_field_relative_kinematics #(
  parameter int GAIN_FRAC_BITS = mfrk_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // yaw_angle, speed_x, speed_y, turn_rate, zero pad
  input  logic [63:0] in_tdata,
  // boost_on, high_power_mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // rpm_front_left, rpm_front_right, rpm_back_left, rpm_back_right, zero pad
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NSTG    = 14;
  localparam int ST_IN   = 0;
  localparam int ST_MUL  = 5;
  localparam int ST_ROT  = 6;
  localparam int ST_LIN  = 7;
  localparam int GW      = GAIN_FRAC_BITS + 3;
  localparam int GAIN_HI  = (58 * (1 << GAIN_FRAC_BITS) + 5) / 10;
  localparam int GAIN_MID = (54 * (1 << GAIN_FRAC_BITS) + 5) / 10;
  localparam int GAIN_LO  = (47 * (1 << GAIN_FRAC_BITS) + 5) / 10;

  mfrk_pkg::cfg_t cfg;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] adv;

  logic signed [15:0] yaw_r;
  logic signed [15:0] sx_r    [ST_MUL];
  logic signed [15:0] sy_r    [ST_MUL];
  logic signed [12:0] turn_r  [ST_ROT];
  logic               boost_r [ST_ROT];
  logic               high_r  [ST_ROT];

  logic signed [15:0] sin_s;
  logic signed [15:0] cos_s;

  logic signed [31:0] pxc_nxt, pys_nxt, pyc_nxt, pxs_nxt;
  logic signed [31:0] pxc_r, pys_r, pyc_r, pxs_r;

  logic signed [32:0] sumx, sumy;
  logic signed [17:0] vx_nxt, vy_nxt, vx_r, vy_r;
  logic signed [13:0] t14, lim_t;
  logic signed [12:0] turnc_nxt, turnc_r;
  logic [GW-1:0]      gain_nxt, gain_r;

  logic signed [17:0] lim_x, lim_y, vxc, vyc;
  logic signed [17:0] lin_nxt [4];
  logic signed [17:0] lin_r   [4];
  logic signed [12:0] turn7_r;
  logic [GW-1:0]      gain7_r;

  logic [11:0]        base;
  logic signed [13:0] base_s, ox2, oy2;
  logic signed [13:0] arm2 [4];
  logic signed [16:0] rpm_w [4];

  mfrk_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // a stage moves when the output is ready or it or any later stage has room
  for (genvar k = 0; k < NSTG; k++) begin : g_adv
    assign adv[k] = out_tready | ~(&v_r[NSTG-1:k]);
  end

  assign in_tready  = adv[ST_IN];
  assign out_tvalid = v_r[NSTG-1];

  always_comb begin
    v_nxt[0] = adv[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      yaw_r      <= $signed(in_tdata[15:0]);
      sx_r[0]    <= $signed(in_tdata[31:16]);
      sy_r[0]    <= $signed(in_tdata[47:32]);
      turn_r[0]  <= $signed(in_tdata[60:48]);
      boost_r[0] <= in_tuser[0];
      high_r[0]  <= in_tuser[1];
    end
    for (int k = 1; k < ST_MUL; k++) begin
      if (adv[k]) begin
        sx_r[k] <= sx_r[k-1];
        sy_r[k] <= sy_r[k-1];
      end
    end
    for (int k = 1; k < ST_ROT; k++) begin
      if (adv[k]) begin
        turn_r[k]  <= turn_r[k-1];
        boost_r[k] <= boost_r[k-1];
        high_r[k]  <= high_r[k-1];
      end
    end
  end

  mfrk_sincos u_sincos (
    .clk   (clk),
    .en    (adv[ST_MUL-1:ST_IN+1]),
    .yaw   (yaw_r),
    .sin_o (sin_s),
    .cos_o (cos_s)
  );

  always_comb begin
    pxc_nxt = cos_s * sx_r[ST_MUL-1];
    pys_nxt = sin_s * sy_r[ST_MUL-1];
    pyc_nxt = cos_s * sy_r[ST_MUL-1];
    pxs_nxt = sin_s * sx_r[ST_MUL-1];
  end

  always_comb begin
    sumx   = 33'(pxc_r) + 33'(pys_r) + 33'sd16384;
    sumy   = 33'(pyc_r) - 33'(pxs_r) + 33'sd16384;
    vx_nxt = sumx[32:15];
    vy_nxt = sumy[32:15];

    t14   = 14'(turn_r[ST_ROT-1]);
    lim_t = $signed({2'b00, cfg.max_turn});
    if (t14 > lim_t) begin
      turnc_nxt = lim_t[12:0];
    end else if (t14 < -lim_t) begin
      turnc_nxt = 13'(-lim_t);
    end else begin
      turnc_nxt = turn_r[ST_ROT-1];
    end

    if (boost_r[ST_ROT-1]) begin
      gain_nxt = high_r[ST_ROT-1] ? GW'(GAIN_HI) : GW'(GAIN_MID);
    end else begin
      gain_nxt = GW'(GAIN_LO);
    end
  end

  always_comb begin
    lim_x = $signed({3'b000, cfg.max_vx});
    lim_y = $signed({3'b000, cfg.max_vy});
    if (vx_r > lim_x) begin
      vxc = lim_x;
    end else if (vx_r < -lim_x) begin
      vxc = -lim_x;
    end else begin
      vxc = vx_r;
    end
    if (vy_r > lim_y) begin
      vyc = lim_y;
    end else if (vy_r < -lim_y) begin
      vyc = -lim_y;
    end else begin
      vyc = vy_r;
    end
    lin_nxt[0] = vxc + vyc;
    lin_nxt[1] = vyc - vxc;
    lin_nxt[2] = vxc - vyc;
    lin_nxt[3] = -vxc - vyc;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      pxc_r <= pxc_nxt;
      pys_r <= pys_nxt;
      pyc_r <= pyc_nxt;
      pxs_r <= pxs_nxt;
    end
    if (adv[ST_ROT]) begin
      vx_r    <= vx_nxt;
      vy_r    <= vy_nxt;
      turnc_r <= turnc_nxt;
      gain_r  <= gain_nxt;
    end
    if (adv[ST_LIN]) begin
      for (int w = 0; w < 4; w++) begin
        lin_r[w] <= lin_nxt[w];
      end
      turn7_r <= turnc_r;
      gain7_r <= gain_r;
    end
  end

  // twice the lever arm per wheel, in mm
  always_comb begin
    base    = {1'b0, cfg.wheelbase} + {1'b0, cfg.wheeltrack};
    base_s  = $signed({2'b00, base});
    ox2     = $signed({{2{cfg.offset_x[10]}}, cfg.offset_x, 1'b0});
    oy2     = $signed({{2{cfg.offset_y[10]}}, cfg.offset_y, 1'b0});
    arm2[0] = base_s - ox2 - oy2;
    arm2[1] = base_s - ox2 + oy2;
    arm2[2] = base_s + ox2 - oy2;
    arm2[3] = base_s + ox2 + oy2;
  end

  for (genvar w = 0; w < 4; w++) begin : g_wheel
    mfrk_wheel #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel (
      .clk       (clk),
      .en        (adv[NSTG-1:ST_LIN+1]),
      .lin       (lin_r[w]),
      .turn      (turn7_r),
      .arm2      (arm2[w]),
      .rpm_scale (cfg.rpm_scale),
      .gain      (gain7_r),
      .rpm_o     (rpm_w[w])
    );
  end

  assign out_tdata = {4'd0, rpm_w[3], rpm_w[2], rpm_w[1], rpm_w[0]};

  a_accept_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[ST_IN])
    else $error("accepted request not captured in the first stage");

  a_blocked_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input blocked while the pipeline has room");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_ROT] && !adv[ST_ROT] |=> v_r[ST_ROT])
    else $error("stalled stage dropped its item");

  a_last_stage_loads: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-2] && adv[NSTG-1] |=> out_tvalid)
    else $error("item lost on the way to the output register");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int GAIN_FRAC_BITS = mfrk_pkg::GAIN_FRAC_BITS_DEF;
  localparam longint GAIN_HI  = (58 * (longint'(1) << GAIN_FRAC_BITS) + 5) / 10;
  localparam longint GAIN_MID = (54 * (longint'(1) << GAIN_FRAC_BITS) + 5) / 10;
  localparam longint GAIN_LO  = (47 * (longint'(1) << GAIN_FRAC_BITS) + 5) / 10;
  localparam longint DEG_TO_RAD_Q16 = 1144;
  localparam longint RPM_MAX = 65535;
  localparam longint RPM_MIN = -65536;

  // sin(k deg) * 32767, k = 0..90
  localparam int SINE_Q15 [91] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14364, 14876, 15383, 15886,
    16384, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
    21062, 21497, 21925, 22347, 22762, 23170, 23571, 23964, 24351, 24730,
    25101, 25465, 25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087,
    28377, 28659, 28932, 29196, 29451, 29697, 29934, 30162, 30381, 30591,
    30791, 30982, 31163, 31335, 31498, 31650, 31794, 31927, 32051, 32165,
    32269, 32364, 32448, 32523, 32587, 32642, 32687, 32722, 32747, 32762,
    32767
  };

  typedef enum int {
    REG_WHEELBASE, REG_TRACK, REG_OFFSET_X, REG_OFFSET_Y,
    REG_RPM_SCALE, REG_MAX_VX, REG_MAX_VY, REG_MAX_TURN
  } reg_idx_t;

  typedef enum int {
    SET_DEFAULT, SET_MAX, SET_MIN, SET_SKEW, SET_NOISE, SET_TYPICAL
  } setting_kind_t;

  localparam logic [31:0] DEFAULT_SET [8] = '{400, 400, 0, 0, 433, 4000, 4000, 360};
  localparam logic [31:0] MAX_SET [8] = '{2047, 2047, 1023, 1023, 65535, 32767, 32767, 4095};
  localparam logic [31:0] MIN_SET [8] = '{0, 0, 32'h400, 32'h400, 0, 0, 0, 0};
  localparam logic [31:0] SKEW_SET [8] = '{2047, 0, 32'h400, 1023, 65535, 32767, 32767, 4095};

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [12:0] turn;
    logic        boost;
    logic        high;
  } request_t;

  // index 0 front left, 1 front right, 2 back left, 3 back right
  typedef logic [3:0][16:0] wheel_set_t;

  function automatic int reg_width(reg_idx_t idx);
    case (idx)
      REG_RPM_SCALE: return 16;
      REG_MAX_VX, REG_MAX_VY: return 15;
      REG_MAX_TURN: return 12;
      default: return 11;
    endcase
  endfunction

  class wheel_speed_board;
    longint wheelbase, track, off_x, off_y, rpm_scale, max_vx, max_vy, max_turn;
    wheel_set_t expected_rpm_q[$];
    int errors;
    int results_checked;

    function new();
      wheelbase = 400;
      track = 400;
      off_x = 0;
      off_y = 0;
      rpm_scale = 433;
      max_vx = 4000;
      max_vy = 4000;
      max_turn = 360;
      errors = 0;
      results_checked = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function int pending();
      return expected_rpm_q.size();
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_WHEELBASE: wheelbase = v[10:0];
        REG_TRACK:     track = v[10:0];
        REG_OFFSET_X:  off_x = $signed(v[10:0]);
        REG_OFFSET_Y:  off_y = $signed(v[10:0]);
        REG_RPM_SCALE: rpm_scale = v[15:0];
        REG_MAX_VX:    max_vx = v[14:0];
        REG_MAX_VY:    max_vy = v[14:0];
        REG_MAX_TURN:  max_turn = v[11:0];
        default: ;
      endcase
    endfunction

    // round to nearest, ties toward plus infinity
    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function int quarter_wave(int x);
      int i, f;
      i = x / 100;
      f = x % 100;
      if (i >= 90) return SINE_Q15[90];
      return SINE_Q15[i] + ((SINE_Q15[i + 1] - SINE_Q15[i]) * f + 50) / 100;
    endfunction

    function int sine_centideg(int t);
      int q, r;
      q = t / 9000;
      r = t % 9000;
      case (q)
        0: return quarter_wave(r);
        1: return quarter_wave(9000 - r);
        2: return -quarter_wave(r);
        default: return -quarter_wave(9000 - r);
      endcase
    endfunction

    function logic [16:0] wheel_target(longint lin, longint turn, longint arm2, longint gain);
      longint s, q, r;
      s = lin * (longint'(1) << 17) - turn * arm2 * DEG_TO_RAD_Q16;
      q = rnd_shift(s * rpm_scale, 17);
      r = rnd_shift(q * gain, 16 + GAIN_FRAC_BITS);
      if (r > RPM_MAX) r = RPM_MAX;
      if (r < RPM_MIN) r = RPM_MIN;
      return r[16:0];
    endfunction

    function void note_request(request_t req);
      longint yaw, sx, sy, turn, t, sn, cs, vx, vy, arm, ox2, oy2, gain;
      wheel_set_t w;
      yaw = $signed(req.yaw);
      sx = $signed(req.sx);
      sy = $signed(req.sy);
      turn = $signed(req.turn);
      t = ((yaw % 36000) + 36000) % 36000;
      sn = sine_centideg(int'(t));
      cs = sine_centideg(int'((t + 9000) % 36000));
      vx = clip(rnd_shift(cs * sx + sn * sy, 15), max_vx);
      vy = clip(rnd_shift(cs * sy - sn * sx, 15), max_vy);
      turn = clip(turn, max_turn);
      arm = wheelbase + track;
      ox2 = 2 * off_x;
      oy2 = 2 * off_y;
      gain = req.boost ? (req.high ? GAIN_HI : GAIN_MID) : GAIN_LO;
      w[0] = wheel_target(vx + vy, turn, arm - ox2 - oy2, gain);
      w[1] = wheel_target(-vx + vy, turn, arm - ox2 + oy2, gain);
      w[2] = wheel_target(vx - vy, turn, arm + ox2 - oy2, gain);
      w[3] = wheel_target(-vx - vy, turn, arm + ox2 + oy2, gain);
      expected_rpm_q.push_back(w);
    endfunction

    function void check_result(logic [71:0] d);
      wheel_set_t exp_w;
      logic [16:0] got;
      string wheel_name;
      if (expected_rpm_q.size() == 0) begin
        report($sformatf("result with no request waiting: %h", d));
        return;
      end
      exp_w = expected_rpm_q.pop_front();
      results_checked++;
      for (int k = 0; k < 4; k++) begin
        got = d[17 * k +: 17];
        if (got !== exp_w[k]) begin
          case (k)
            0: wheel_name = "front_left";
            1: wheel_name = "front_right";
            2: wheel_name = "back_left";
            default: wheel_name = "back_right";
          endcase
          report($sformatf("result %0d rpm_%s: expected %0d, got %0d", results_checked,
                           wheel_name, $signed(exp_w[k]), $signed(got)));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  wheel_speed_board sb;
  int idle_mode;
  int requests_sent;
  int settings_applied;

  mecanum_field_relative_kinematics #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int draw_gap();
    case (idle_mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  function automatic request_t make_request(int yaw, int sx, int sy, int turn,
                                            bit boost, bit high);
    request_t r;
    r.yaw = 16'(yaw);
    r.sx = 16'(sx);
    r.sy = 16'(sy);
    r.turn = 13'(turn);
    r.boost = boost;
    r.high = high;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      r.yaw = 16'($urandom_range(0, 36000) - 18000);
    end else if (sel < 8) begin
      // near a quadrant boundary
      r.yaw = 16'(9000 * $urandom_range(0, 4) - 18000 + $urandom_range(0, 6) - 3);
    end else begin
      r.yaw = 16'($urandom);
    end
    r.sx = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10000) - 5000);
    r.sy = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10000) - 5000);
    r.turn = ($urandom_range(0, 1) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1600) - 800);
    r.boost = 1'($urandom);
    r.high = 1'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] setting_value(setting_kind_t kind, reg_idx_t idx);
    case (kind)
      SET_DEFAULT: return DEFAULT_SET[idx];
      SET_MAX:     return MAX_SET[idx];
      SET_MIN:     return MIN_SET[idx];
      SET_SKEW:    return SKEW_SET[idx];
      SET_NOISE:   return $urandom;
      default: begin
        case (idx)
          REG_WHEELBASE, REG_TRACK: return $urandom_range(200, 800);
          REG_OFFSET_X, REG_OFFSET_Y: return 32'($urandom_range(0, 200)) - 32'd100;
          REG_RPM_SCALE: return $urandom_range(100, 3000);
          REG_MAX_VX, REG_MAX_VY: return $urandom_range(500, 8000);
          default: return $urandom_range(30, 720);
        endcase
      end
    endcase
  endfunction

  // caller stands just after a falling edge
  task automatic send_request(request_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, r.turn, r.sy, r.sx, r.yaw};
    in_tuser <= {r.high, r.boost};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // write, then read back; psel stays high between back-to-back calls
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    logic [31:0] mask;
    mask = (32'd1 << reg_width(idx)) - 32'd1;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 5'(int'(idx) * 4);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (((cfg_prdata ^ value) & mask) != 32'd0) begin
      sb.report($sformatf("register %0d read back %h, wrote %h", int'(idx),
                          cfg_prdata & mask, value & mask));
    end
  endtask

  task automatic apply_setting(setting_kind_t kind);
    for (int i = 0; i < 8; i++) begin
      write_reg(reg_idx_t'(i), setting_value(kind, reg_idx_t'(i)));
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    settings_applied++;
  endtask

  // output side: random stalls on out_tready
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    setting_kind_t plan [10];
    plan = '{SET_MAX, SET_MIN, SET_SKEW, SET_DEFAULT, SET_NOISE,
             SET_TYPICAL, SET_NOISE, SET_TYPICAL, SET_NOISE, SET_TYPICAL};
    sb = new();
    idle_mode = 1;
    requests_sent = 0;
    settings_applied = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests at reset settings
    send_request(make_request(0, 0, 0, 0, 0, 0));
    send_request(make_request(0, 32767, 0, 0, 0, 0));
    send_request(make_request(9000, 1000, 0, 0, 0, 0));
    send_request(make_request(-9000, 0, 1000, 0, 0, 0));
    send_request(make_request(18000, 1000, 500, 0, 0, 0));
    send_request(make_request(-18000, 1000, 500, 0, 0, 0));
    send_request(make_request(32767, 1500, -700, 20, 0, 0));
    send_request(make_request(-32768, -1500, 700, -20, 0, 0));
    send_request(make_request(4550, -1000, 2000, 0, 0, 0));
    send_request(make_request(8999, 3000, -3000, 0, 0, 0));
    send_request(make_request(27000, 2000, 0, 0, 0, 0));
    send_request(make_request(0, 0, 0, 4095, 0, 0));
    send_request(make_request(0, 0, 0, -4096, 0, 0));
    send_request(make_request(1234, -32768, -32768, 0, 0, 0));
    send_request(make_request(0, 32767, 32767, 0, 1, 1));
    send_request(make_request(0, 32767, 32767, 0, 1, 0));
    send_request(make_request(0, 32767, 32767, 0, 0, 1));
    send_request(make_request(-4321, 1500, -800, 100, 1, 1));
    send_request(make_request(12345, 32767, -32768, -4096, 1, 1));
    send_request(make_request(-1, 1, -1, 1, 0, 0));
    send_request(make_request(100, -1, 1, -1, 1, 0));
    settle();

    for (int p = 0; p < 10; p++) begin
      apply_setting(plan[p]);
      for (int n = 0; n < 65; n++) begin
        if (n % 32 == 0) idle_mode = $urandom_range(0, 2);
        send_request(random_request());
      end
      settle();
    end

    $display("sent %0d requests and checked %0d results across %0d register settings",
             requests_sent, sb.results_checked, settings_applied);
    $display("%0d errors counted", sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
